@@ src/thresholded_vector_distance_assert.svh @@
// Assertion macros for the thresholded vector distance block
`ifndef THRESHOLDED_VECTOR_DISTANCE_ASSERT_SVH
`define THRESHOLDED_VECTOR_DISTANCE_ASSERT_SVH
`ifndef SYNTHESIS
`define TVD_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("label");
`define TVD_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("label");
`else
`define TVD_ASSERT(label, clk, rst_n, prop)
`define TVD_ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

@@ src/tvd_pkg.sv @@
// Shared types and constants for the thresholded vector distance block
`timescale 1ns / 1ps
package tvd_pkg;
    localparam logic [1:0] MODE_EUCLID = 2'd0;
    localparam logic [1:0] MODE_MANHATTAN = 2'd1;
    localparam logic [1:0] MODE_COSINE = 2'd2;
    localparam logic [1:0] ERR_OK = 2'd0;
    localparam logic [1:0] ERR_OVERFLOW = 2'd1;
    localparam logic [1:0] ERR_ZERO_VEC = 2'd2;
    localparam logic REG_MODE = 1'b0;
    localparam logic REG_THRESHOLD = 1'b1;
    localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
    localparam logic [31:0] MAX_DIST = 32'hFFFF_FFFF;
    localparam int unsigned MAX_POINTS = 32'd65536;

    typedef struct packed {
        logic signed [31:0] coord_a;
        logic signed [31:0] coord_b;
        logic [15:0] index_a;
        logic [15:0] index_b;
        logic last_coord;
    } in_item_t;

    typedef struct packed {
        logic [31:0] distance;
        logic is_edge;
        logic [1:0] error_code;
        logic [15:0] pair_first;
        logic [15:0] pair_second;
    } out_item_t;

    typedef struct packed {
        logic acc_en;
        logic fin_start;
        logic sqrt_a_start;
        logic sqrt_b_start;
        logic mul_start;
        logic div_start;
        logic result_load;
    } dp_cmd_t;

    typedef struct packed {
        logic last;
        logic sqrt_done;
        logic div_done;
        logic mode_cosine;
    } dp_status_t;
endpackage

@@ src/tvd_datapath.sv @@
// Accumulators, square root and divide unit of the thresholded vector distance block
`timescale 1ns / 1ps
`include "thresholded_vector_distance_assert.svh"
module tvd_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  tvd_pkg::dp_cmd_t     cmd,
    output tvd_pkg::dp_status_t  status,
    input  tvd_pkg::in_item_t    in_item,
    input  logic [1:0]           mode,
    input  logic [31:0]          threshold,
    output tvd_pkg::out_item_t   result
);
    logic [63:0] diff_sum_reg;
    logic signed [63:0] dot_sum_reg;
    logic [63:0] norm_a_sum_reg;
    logic [63:0] norm_b_sum_reg;
    logic overflow_seen_reg;

    logic [1:0] fmode_reg;
    logic [15:0] ia_reg;
    logic [15:0] ib_reg;
    logic last_reg;

    // product stage
    logic [65:0] sq_reg;
    logic [32:0] ad_reg;
    logic signed [63:0] ab_reg;
    logic [63:0] aa_reg;
    logic [63:0] bb_reg;
    logic [1:0] pmode_reg;
    logic pvalid_reg;

    logic signed [32:0] diff;
    logic [32:0] ad;
    assign diff = 33'(in_item.coord_a) - 33'(in_item.coord_b);
    assign ad = diff[32] ? 33'(-diff) : diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvalid_reg <= 1'b0;
        end
        else
        begin
            pvalid_reg <= cmd.acc_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.acc_en)
        begin
            ad_reg <= ad;
            sq_reg <= 66'(ad) * 66'(ad);
            ab_reg <= 64'(in_item.coord_a) * 64'(in_item.coord_b);
            aa_reg <= 64'(64'(in_item.coord_a) * 64'(in_item.coord_a));
            bb_reg <= 64'(64'(in_item.coord_b) * 64'(in_item.coord_b));
            pmode_reg <= mode;
            last_reg <= in_item.last_coord;
            ia_reg <= in_item.index_a;
            ib_reg <= in_item.index_b;
        end
    end

    logic [64:0] add_d;
    logic [64:0] add_a;
    logic [64:0] add_b;
    logic signed [64:0] add_s;
    always_comb
    begin
        add_d = (pmode_reg == tvd_pkg::MODE_MANHATTAN) ? 65'(diff_sum_reg) + 65'(ad_reg)
                                                      : 65'(diff_sum_reg) + sq_reg[64:0];
        add_a = 65'(norm_a_sum_reg) + 65'(aa_reg);
        add_b = 65'(norm_b_sum_reg) + 65'(bb_reg);
        add_s = 65'(dot_sum_reg) + 65'(ab_reg);
    end

    // sqrt unit, 32 steps
    logic [63:0] sq_v_reg;
    logic [63:0] sq_r_reg;
    logic [5:0] sq_cnt_reg;
    logic sq_busy_reg;
    logic [31:0] sa_reg;
    logic [31:0] sb_reg;
    logic sq_to_b_reg;
    logic [63:0] sq_bit;
    logic [63:0] sq_trial;
    assign sq_bit = 64'd1 << {sq_cnt_reg[4:0], 1'b0};
    assign sq_trial = sq_r_reg + sq_bit;

    // divide unit, 16 steps
    logic [63:0] den_reg;
    logic [63:0] rem_reg;
    logic [16:0] q_reg;
    logic [4:0] dv_cnt_reg;
    logic dv_busy_reg;
    logic [63:0] mag;
    logic [64:0] rsh;
    assign mag = dot_sum_reg[63] ? 64'(-dot_sum_reg) : 64'(dot_sum_reg);
    assign rsh = {rem_reg, 1'b0};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_sum_reg <= '0;
            dot_sum_reg <= '0;
            norm_a_sum_reg <= '0;
            norm_b_sum_reg <= '0;
            overflow_seen_reg <= 1'b0;
            fmode_reg <= tvd_pkg::MODE_EUCLID;
            sq_busy_reg <= 1'b0;
            dv_busy_reg <= 1'b0;
            sq_cnt_reg <= '0;
            dv_cnt_reg <= '0;
        end
        else
        begin
            if (pvalid_reg)
            begin
                if (pmode_reg == tvd_pkg::MODE_COSINE)
                begin
                    if (add_a[64])
                    begin
                        norm_a_sum_reg <= '1;
                    end
                    else
                    begin
                        norm_a_sum_reg <= add_a[63:0];
                    end
                    if (add_b[64])
                    begin
                        norm_b_sum_reg <= '1;
                    end
                    else
                    begin
                        norm_b_sum_reg <= add_b[63:0];
                    end
                    if (add_s[64] != add_s[63])
                    begin
                        dot_sum_reg <= add_s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
                    end
                    else
                    begin
                        dot_sum_reg <= add_s[63:0];
                    end
                    overflow_seen_reg <= overflow_seen_reg || add_a[64] || add_b[64]
                                         || (add_s[64] != add_s[63]);
                end
                else if (add_d[64] || (pmode_reg != tvd_pkg::MODE_MANHATTAN && sq_reg[65]))
                begin
                    diff_sum_reg <= '1;
                    overflow_seen_reg <= 1'b1;
                end
                else
                begin
                    diff_sum_reg <= add_d[63:0];
                end
            end
            if (cmd.fin_start)
            begin
                fmode_reg <= pmode_reg;
            end
            if (cmd.sqrt_a_start || cmd.sqrt_b_start)
            begin
                sq_busy_reg <= 1'b1;
                sq_cnt_reg <= 6'd31;
                sq_r_reg <= '0;
                sq_to_b_reg <= cmd.sqrt_b_start;
                sq_v_reg <= cmd.sqrt_b_start ? norm_b_sum_reg
                          : (fmode_reg == tvd_pkg::MODE_COSINE ? norm_a_sum_reg : diff_sum_reg);
            end
            else if (sq_busy_reg)
            begin
                if (sq_v_reg >= sq_trial)
                begin
                    sq_v_reg <= sq_v_reg - sq_trial;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit;
                end
                else
                begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_cnt_reg <= sq_cnt_reg - 6'd1;
                if (sq_cnt_reg == 6'd0)
                begin
                    sq_busy_reg <= 1'b0;
                end
            end
            if (cmd.mul_start)
            begin
                den_reg <= 64'(sa_reg) * 64'(sb_reg);
            end
            if (cmd.div_start)
            begin
                dv_busy_reg <= 1'b1;
                dv_cnt_reg <= (mag >= den_reg) ? 5'd0 : 5'd16;
                rem_reg <= mag;
                q_reg <= (mag >= den_reg) ? 17'(tvd_pkg::ONE_Q16) : '0;
            end
            else if (dv_busy_reg)
            begin
                if (dv_cnt_reg == 5'd0)
                begin
                    dv_busy_reg <= 1'b0;
                end
                else
                begin
                    if (rsh[64] || rsh[63:0] >= den_reg)
                    begin
                        rem_reg <= rsh[63:0] - den_reg;
                        q_reg <= {q_reg[15:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= rsh[63:0];
                        q_reg <= {q_reg[15:0], 1'b0};
                    end
                    dv_cnt_reg <= dv_cnt_reg - 5'd1;
                end
            end
            if (cmd.result_load)
            begin
                diff_sum_reg <= '0;
                dot_sum_reg <= '0;
                norm_a_sum_reg <= '0;
                norm_b_sum_reg <= '0;
                overflow_seen_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (sq_busy_reg && sq_cnt_reg == 6'd0)
        begin
            if (sq_to_b_reg)
            begin
                sb_reg <= sq_v_reg >= sq_trial ? 32'((sq_r_reg >> 1) + sq_bit)
                                               : 32'(sq_r_reg >> 1);
            end
            else
            begin
                sa_reg <= sq_v_reg >= sq_trial ? 32'((sq_r_reg >> 1) + sq_bit)
                                               : 32'(sq_r_reg >> 1);
            end
        end
    end

    logic [31:0] dist_val;
    logic [1:0] err;
    always_comb
    begin
        dist_val = '0;
        err = tvd_pkg::ERR_OK;
        unique case (fmode_reg)
            tvd_pkg::MODE_MANHATTAN:
            begin
                dist_val = (diff_sum_reg[63:32] != '0) ? tvd_pkg::MAX_DIST
                                                       : diff_sum_reg[31:0];
                if (diff_sum_reg[63:32] != '0)
                begin
                    err = tvd_pkg::ERR_OVERFLOW;
                end
            end
            tvd_pkg::MODE_COSINE:
            begin
                if (den_reg == '0)
                begin
                    err = tvd_pkg::ERR_ZERO_VEC;
                end
                else
                begin
                    dist_val = dot_sum_reg[63] ? tvd_pkg::ONE_Q16 + 32'(q_reg)
                                               : tvd_pkg::ONE_Q16 - 32'(q_reg);
                end
            end
            default:
            begin
                dist_val = sa_reg;
            end
        endcase
        if (overflow_seen_reg)
        begin
            err = tvd_pkg::ERR_OVERFLOW;
            dist_val = tvd_pkg::MAX_DIST;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            result.distance <= dist_val;
            result.is_edge <= (err == tvd_pkg::ERR_OK) && (dist_val <= threshold);
            result.error_code <= err;
            result.pair_first <= ia_reg;
            result.pair_second <= ib_reg;
        end
    end

    assign status.last = last_reg;
    assign status.sqrt_done = !sq_busy_reg;
    assign status.div_done = !dv_busy_reg;
    assign status.mode_cosine = (fmode_reg == tvd_pkg::MODE_COSINE);

    `TVD_ASSERT(a_sqrt_single, clk, rst_n, (cmd.sqrt_a_start |-> !sq_busy_reg))
    `TVD_ASSERT(a_div_single, clk, rst_n, (cmd.div_start |-> !dv_busy_reg))
    `TVD_ASSERT_NEVER(a_no_acc_during_load, clk, rst_n, (cmd.result_load && pvalid_reg))
endmodule

@@ src/tvd_control.sv @@
// Sequencer for the thresholded vector distance block
`timescale 1ns / 1ps
`include "thresholded_vector_distance_assert.svh"
module tvd_control (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tvd_pkg::dp_cmd_t     cmd,
    input  tvd_pkg::dp_status_t  status
);
    localparam logic [3:0] S_ACC = 4'd0;
    localparam logic [3:0] S_PROD = 4'd1;
    localparam logic [3:0] S_ADD = 4'd2;
    localparam logic [3:0] S_SQA = 4'd3;
    localparam logic [3:0] S_SQB = 4'd4;
    localparam logic [3:0] S_MUL = 4'd5;
    localparam logic [3:0] S_DIVS = 4'd6;
    localparam logic [3:0] S_DIV = 4'd7;
    localparam logic [3:0] S_LOAD = 4'd8;
    localparam logic [3:0] S_OUT = 4'd9;
    localparam logic [3:0] S_WSQ = 4'd10;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic out_valid_reg;
    logic out_valid_next;

    always_comb
    begin
        state_next = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            S_ACC:
            begin
                in_ready = 1'b1;
                cmd.acc_en = in_valid;
                if (in_valid)
                begin
                    state_next = S_PROD;
                end
            end
            S_PROD:
            begin
                state_next = S_ADD;
            end
            S_ADD:
            begin
                // accumulators settle this cycle
                cmd.fin_start = status.last;
                state_next = status.last ? S_SQA : S_ACC;
            end
            S_SQA:
            begin
                cmd.sqrt_a_start = 1'b1;
                state_next = S_WSQ;
            end
            S_WSQ:
            begin
                if (status.sqrt_done)
                begin
                    state_next = status.mode_cosine ? S_SQB : S_LOAD;
                end
            end
            S_SQB:
            begin
                if (status.sqrt_done)
                begin
                    cmd.sqrt_b_start = 1'b1;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                if (status.sqrt_done)
                begin
                    cmd.mul_start = 1'b1;
                    state_next = S_DIVS;
                end
            end
            S_DIVS:
            begin
                cmd.div_start = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (status.div_done)
                begin
                    state_next = S_LOAD;
                end
            end
            S_LOAD:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.result_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = S_ACC;
                end
            end
            default:
            begin
                state_next = S_ACC;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_ACC;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `TVD_ASSERT(a_load_frees, clk, rst_n, (cmd.result_load |=> out_valid))
    `TVD_ASSERT(a_accept_prod, clk, rst_n, ((in_valid && in_ready) |=> (state_reg == S_PROD)))
    `TVD_ASSERT_NEVER(a_ready_busy, clk, rst_n, (in_ready && state_reg != S_ACC))
endmodule

@@ src/thresholded_vector_distance.sv @@
// Top level of the thresholded vector distance block
`timescale 1ns / 1ps
// Streams one coordinate pair per transaction and accumulates Euclidean, Manhattan or
// cosine sums in 64-bit saturating registers. A coordinate without the last mark passes
// through the product register and the accumulate step before the next is accepted. On
// the last mark the finisher runs a 32-step bit-serial square root (twice for cosine)
// and, for cosine, a 16-step restoring divide, skipped when the dot product magnitude
// reaches the norm product. No new transaction is accepted until the result is loaded,
// which also waits while the output register is full. The result waits in an output
// register. The metric is taken per coordinate; the result uses the metric of the
// marked coordinate. Point indices pass through unchecked.
module thresholded_vector_distance (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  tvd_pkg::in_item_t    in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output tvd_pkg::out_item_t   out_data,
    input  logic                 cfg_we,
    input  logic                 cfg_index,
    input  logic [31:0]          cfg_data
);
    logic [1:0] mode_reg;
    logic [31:0] threshold_reg;
    tvd_pkg::dp_cmd_t cmd;
    tvd_pkg::dp_status_t status;
    tvd_pkg::out_item_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= tvd_pkg::MODE_EUCLID;
            threshold_reg <= tvd_pkg::ONE_Q16;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                tvd_pkg::REG_MODE:      mode_reg <= cfg_data[1:0];
                tvd_pkg::REG_THRESHOLD: threshold_reg <= cfg_data;
                default:                mode_reg <= mode_reg;
            endcase
        end
    end

    tvd_control u_control (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd),
        .status    (status)
    );

    tvd_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_item   (in_data),
        .mode      (mode_reg),
        .threshold (threshold_reg),
        .result    (result)
    );

    assign out_data = result;
endmodule

@@ tb/thresholded_vector_distance_checker.sv @@
// Checker for the thresholded vector distance block: predicts results and compares them
`timescale 1ns / 1ps
module thresholded_vector_distance_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_ready,
    input  tvd_pkg::in_item_t  in_data,
    input  logic               out_valid,
    input  logic               out_ready,
    input  tvd_pkg::out_item_t out_data,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 fail_count,
    output int                 pending,
    output int                 result_count
);
    logic [1:0]         mode;
    logic [31:0]        threshold;
    logic [63:0]        sq_sum;
    logic signed [63:0] dot_acc;
    logic [63:0]        norm_a;
    logic [63:0]        norm_b;
    logic               sat_seen;
    tvd_pkg::out_item_t expected_q[$];

    assign pending = expected_q.size();

    function automatic logic [31:0] int_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    function automatic logic [63:0] add_unsigned(input logic [63:0] s, input logic [63:0] p);
        logic [64:0] t;
        t = {1'b0, s} + {1'b0, p};
        if (t[64])
        begin
            sat_seen = 1'b1;
            return '1;
        end
        return t[63:0];
    endfunction

    task automatic accumulate(input tvd_pkg::in_item_t it);
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] d;
        logic signed [63:0] p;
        logic [63:0]        ad;
        logic [63:0]        mag;
        logic [63:0]        den;
        logic [63:0]        r;
        logic [31:0]        q;
        logic [31:0]        dist_val;
        logic [1:0]         err;
        logic               carry;
        tvd_pkg::out_item_t res;
        a = it.coord_a;
        b = it.coord_b;
        d = a - b;
        ad = d < 0 ? -d : d;
        if (mode == tvd_pkg::MODE_MANHATTAN)
            sq_sum = add_unsigned(sq_sum, ad);
        else if (mode == tvd_pkg::MODE_COSINE)
        begin
            p = a * b;
            if (p > 0 && dot_acc > 64'sh7FFF_FFFF_FFFF_FFFF - p)
            begin
                sat_seen = 1'b1;
                dot_acc = 64'sh7FFF_FFFF_FFFF_FFFF;
            end
            else if (p < 0 && dot_acc < $signed(64'h8000_0000_0000_0000) - p)
            begin
                sat_seen = 1'b1;
                dot_acc = $signed(64'h8000_0000_0000_0000);
            end
            else
                dot_acc = dot_acc + p;
            norm_a = add_unsigned(norm_a, a * a);
            norm_b = add_unsigned(norm_b, b * b);
        end
        else
            sq_sum = add_unsigned(sq_sum, ad * ad);
        if (!it.last_coord)
            return;
        dist_val = 0;
        err = tvd_pkg::ERR_OK;
        if (mode == tvd_pkg::MODE_MANHATTAN)
        begin
            if (sq_sum > {32'd0, tvd_pkg::MAX_DIST})
                sat_seen = 1'b1;
            else
                dist_val = sq_sum[31:0];
        end
        else if (mode == tvd_pkg::MODE_COSINE)
        begin
            den = {32'd0, int_sqrt(norm_a)} * {32'd0, int_sqrt(norm_b)};
            if (!sat_seen && den == 0)
                err = tvd_pkg::ERR_ZERO_VEC;
            else if (!sat_seen)
            begin
                mag = dot_acc < 0 ? -dot_acc : dot_acc;
                q = 0;
                if (mag >= den)
                    q = tvd_pkg::ONE_Q16;
                else
                begin
                    r = mag;
                    for (int k = 0; k < 16; k++)
                    begin
                        carry = r[63];
                        r = r << 1;
                        q = q << 1;
                        if (carry || r >= den)
                        begin
                            r = r - den;
                            q[0] = 1'b1;
                        end
                    end
                end
                dist_val = dot_acc < 0 ? tvd_pkg::ONE_Q16 + q : tvd_pkg::ONE_Q16 - q;
            end
        end
        else
            dist_val = int_sqrt(sq_sum);
        if (sat_seen)
        begin
            err = tvd_pkg::ERR_OVERFLOW;
            dist_val = tvd_pkg::MAX_DIST;
        end
        res.distance = dist_val;
        res.is_edge = (err == tvd_pkg::ERR_OK) && (dist_val <= threshold);
        res.error_code = err;
        res.pair_first = it.index_a;
        res.pair_second = it.index_b;
        expected_q.push_back(res);
        sq_sum = 0;
        dot_acc = 0;
        norm_a = 0;
        norm_b = 0;
        sat_seen = 0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode <= tvd_pkg::MODE_EUCLID;
            threshold <= tvd_pkg::ONE_Q16;
            sq_sum = 0;
            dot_acc = 0;
            norm_a = 0;
            norm_b = 0;
            sat_seen = 0;
            expected_q.delete();
            fail_count <= 0;
            result_count <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                result_count <= result_count + 1;
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, actual %p", $time, out_data);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    tvd_pkg::out_item_t e;
                    e = expected_q.pop_front();
                    if (e !== out_data)
                    begin
                        $display("%0t: mismatch, expected %p actual %p", $time, e, out_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (in_valid && in_ready)
                accumulate(in_data);
            if (cfg_we)
            begin
                if (cfg_index == tvd_pkg::REG_MODE)
                    mode <= cfg_data[1:0];
                else
                    threshold <= cfg_data;
            end
        end
    end
endmodule

@@ tb/thresholded_vector_distance_test.sv @@
// Testbench top for the thresholded vector distance block: stimulus and verdict
`timescale 1ns / 1ps
module thresholded_vector_distance_test;
    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    tvd_pkg::in_item_t  in_data;
    logic               out_valid;
    logic               out_ready;
    tvd_pkg::out_item_t out_data;
    logic               cfg_we;
    logic               cfg_index;
    logic [31:0]        cfg_data;
    int                 fail_count;
    int                 pending;
    int                 result_count;
    int                 sent;
    int                 rx_wait;
    int                 rx_draw;
    bit                 stall_go;
    logic               long_stall;
    bit                 stim_done;

    thresholded_vector_distance dut (.*);

    thresholded_vector_distance_checker checker_i (.*);

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #50_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // hold the receiver off for a long stretch once requested
    initial
    begin
        long_stall = 1'b0;
        wait (stall_go);
        @(posedge clk);
        long_stall <= 1'b1;
        repeat (400) @(posedge clk);
        long_stall <= 1'b0;
    end

    task automatic send(input tvd_pkg::in_item_t it);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (150) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [31:0] val);
        in_valid <= 1'b0;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'd0;
            3: return $urandom;
            default: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
        endcase
    endfunction

    task automatic send_vector(input int len, input bit zero_a);
        tvd_pkg::in_item_t it;
        logic [15:0] ia;
        logic [15:0] ib;
        ia = 16'($urandom);
        ib = 16'($urandom);
        for (int k = 0; k < len; k++)
        begin
            it.coord_a = zero_a ? 32'd0 : rand_coord();
            it.coord_b = rand_coord();
            it.index_a = $urandom_range(0, 7) == 0 ? 16'($urandom) : ia;
            it.index_b = ib;
            it.last_coord = (k == len - 1);
            send(it);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_wait <= 0;
        end
        else if (long_stall)
            out_ready <= 1'b0;
        else if (out_valid && out_ready)
        begin
            rx_draw = $urandom_range(0, 12);
            rx_wait <= rx_draw;
            out_ready <= (rx_draw == 0);
        end
        else if (rx_wait > 1)
        begin
            rx_wait <= rx_wait - 1;
            out_ready <= 1'b0;
        end
        else
        begin
            rx_wait <= 0;
            out_ready <= 1'b1;
        end
    end

    initial
    begin
        tvd_pkg::in_item_t it;
        logic [31:0] thr[4];
        thr = '{32'd0, 32'hFFFF_FFFF, 32'h0001_0000, 32'h0040_0000};
        rst_n = 0;
        in_valid = 0;
        in_data = '0;
        cfg_we = 0;
        cfg_index = tvd_pkg::REG_MODE;
        cfg_data = 0;
        sent = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int m = 0; m < 4; m++)
        begin
            write_reg(tvd_pkg::REG_MODE, 32'(m));
            write_reg(tvd_pkg::REG_THRESHOLD, thr[m]);
            it = '{32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 16'h0000, 1'b0};
            send(it);
            it = '{32'h7FFF_FFFF, 32'h8000_0000, 16'h0000, 16'hFFFF, 1'b1};
            send(it);
            it = '{32'h0001_0000, 32'h0001_0000, 16'h1234, 16'h4321, 1'b1};
            send(it);
            it = '{32'h0, 32'h0, 16'h1, 16'h2, 1'b1};
            send(it);
            it = '{32'h0001_0000, 32'hFFFF_0000, 16'h3, 16'h4, 1'b1};
            send(it);
            drain();
        end
        write_reg(tvd_pkg::REG_MODE, 32'(tvd_pkg::MODE_COSINE));
        for (int k = 0; k < 4; k++)
        begin
            it = '{32'h8000_0000, 32'h8000_0000, 16'h5, 16'h6, 1'b0};
            send(it);
        end
        it = '{32'h8000_0000, 32'h0, 16'h5, 16'h6, 1'b1};
        send(it);
        write_reg(tvd_pkg::REG_MODE, 32'(tvd_pkg::MODE_MANHATTAN));
        it = '{32'h0, 32'h0001_0000, 16'h7, 16'h8, 1'b0};
        send(it);
        write_reg(tvd_pkg::REG_MODE, 32'(tvd_pkg::MODE_EUCLID));
        it = '{32'h0, 32'h0001_0000, 16'h7, 16'h8, 1'b1};
        send(it);
        drain();
        for (int phase = 0; phase < 8; phase++)
        begin
            write_reg(tvd_pkg::REG_MODE, $urandom_range(0, 3));
            write_reg(tvd_pkg::REG_THRESHOLD, $urandom_range(0, 1) ? $urandom
                                                          : $urandom_range(0, 32'h0010_0000));
            if (phase == 2)
                stall_go = 1'b1;
            while (sent < 120 + phase * 185)
                send_vector($urandom_range(0, 9) == 0 ? $urandom_range(9, 16)
                                                      : $urandom_range(1, 4),
                            $urandom_range(0, 15) == 0);
            drain();
        end
        stim_done = 1;
    end

    initial
    begin
        wait (stim_done);
        $display("Sent %0d coordinate transactions and checked %0d results", sent,
                 result_count);
        $display("over all metrics, threshold extremes, saturation and zero vectors");
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule

@@ thresholded_vector_distance.f @@
+incdir+src
src/tvd_pkg.sv
src/tvd_datapath.sv
src/tvd_control.sv
src/thresholded_vector_distance.sv
tb/thresholded_vector_distance_checker.sv
tb/thresholded_vector_distance_test.sv
